FILE: rtl/svp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svp_pkg
// Shared constants, codes and types of the smooth velocity profile unit.
// ----------------------------------------------------------------------------
package svp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    // dividend of the setup divisions: a 32-bit value shifted up by at most FRAC_BITS + 1
    localparam int NUM_W     = DATA_W + FRAC_BITS + 1;
    // room for tm = q + x and for 2*tm - x
    localparam int LIM_W     = NUM_W + 2;
    // ramp divisor x * 2^FRAC_BITS
    localparam int DEN_W     = NUM_W + FRAC_BITS;
    localparam int SQ_W      = 2 * DATA_W;
    localparam int PROD_W    = 3 * DATA_W;
    localparam int CNT_W     = $clog2(NUM_W + 1);
    localparam int IDX_W     = 2;

    localparam logic [IDX_W-1:0] REG_DIST = 2'd0;
    localparam logic [IDX_W-1:0] REG_ACC  = 2'd1;
    localparam logic [IDX_W-1:0] REG_VEL  = 2'd2;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_RISE1  = 3'd1;
    localparam logic [2:0] PH_RISE2  = 3'd2;
    localparam logic [2:0] PH_CRUISE = 3'd3;
    localparam logic [2:0] PH_FALL1  = 3'd4;
    localparam logic [2:0] PH_FALL2  = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;

    localparam logic [1:0] KIND_DIRECT = 2'd0;
    localparam logic [1:0] KIND_RAMP   = 2'd1;
    localparam logic [1:0] KIND_SUB    = 2'd2;

    localparam logic [DATA_W-1:0] ONE_VAL = DATA_W'(1) << FRAC_BITS;
    localparam logic [DATA_W-1:0] MAX_VAL = '1;

    typedef struct packed {
        logic [NUM_W-1:0] x;
        logic [NUM_W-1:0] q;
        logic [LIM_W-1:0] tm;
        logic [LIM_W-1:0] lim4;
    } svp_limits_t;

    typedef struct packed {
        logic [2:0]        phase;
        logic              err;
        logic [1:0]        kind;
        logic [DATA_W-1:0] dt;
        logic [DATA_W-1:0] direct;
    } svp_item_t;

    typedef struct packed {
        logic [2:0]        phase;
        logic              err;
        logic [1:0]        kind;
        logic [DATA_W-1:0] direct;
    } svp_meta_t;

endpackage
`default_nettype wire

FILE: rtl/svp_setup.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svp_setup
// Configuration registers and a serial divider that derives the ramp time,
// the cruise end and the ramp-down limits after every register write.
// ----------------------------------------------------------------------------
module svp_setup (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [svp_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [svp_pkg::DATA_W-1:0] cfg_data,
    output logic [svp_pkg::DATA_W-1:0]      acc,
    output logic [svp_pkg::DATA_W-1:0]      vel,
    output svp_pkg::svp_limits_t            lim,
    output logic                            busy
);
    import svp_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_DIV_X = 3'd2;
    localparam logic [2:0] S_DIV_Q = 3'd3;
    localparam logic [2:0] S_SUM   = 3'd4;
    localparam logic [2:0] S_LIM   = 3'd5;

    logic [DATA_W-1:0] dist_reg, acc_reg, vel_reg;
    logic [2:0]        state_reg, state_next;
    logic [NUM_W-1:0]  work_reg, work_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [NUM_W-1:0]  x_reg, x_next, q_reg, q_next;
    logic [LIM_W-1:0]  tm_reg, tm_next, lim4_reg, lim4_next;
    logic [DATA_W-1:0] divisor;
    logic [DATA_W:0]   rem_sh, rem_diff;
    logic              ge;
    logic              last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg <= ONE_VAL;
            acc_reg  <= ONE_VAL;
            vel_reg  <= ONE_VAL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DIST: dist_reg <= cfg_data;
                REG_ACC:  acc_reg  <= cfg_data;
                REG_VEL:  vel_reg  <= cfg_data;
                default:  ;
            endcase
        end
    end

    assign divisor  = (state_reg == S_DIV_X) ? acc_reg : vel_reg;
    assign rem_sh   = {rem_reg, work_reg[NUM_W-1]};
    assign ge       = rem_sh >= {1'b0, divisor};
    assign rem_diff = rem_sh - {1'b0, divisor};
    assign last     = cnt_reg == CNT_W'(NUM_W - 1);

    always_comb
    begin
        state_next = state_reg;
        work_next  = work_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        x_next     = x_reg;
        q_next     = q_reg;
        tm_next    = tm_reg;
        lim4_next  = lim4_reg;
        case (state_reg)
            S_IDLE: ;
            S_LOAD:
            begin
                work_next  = {vel_reg, (FRAC_BITS + 1)'(0)};
                rem_next   = '0;
                cnt_next   = '0;
                state_next = S_DIV_X;
            end
            S_DIV_X, S_DIV_Q:
            begin
                // one quotient bit per cycle, restoring
                work_next = {work_reg[NUM_W-2:0], ge};
                rem_next  = ge ? rem_diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
                cnt_next  = cnt_reg + CNT_W'(1);
                if (last)
                begin
                    rem_next = '0;
                    cnt_next = '0;
                    if (state_reg == S_DIV_X)
                    begin
                        x_next     = work_next;
                        work_next  = {1'b0, dist_reg, FRAC_BITS'(0)};
                        state_next = S_DIV_Q;
                    end
                    else
                    begin
                        q_next     = work_next;
                        state_next = S_SUM;
                    end
                end
            end
            S_SUM:
            begin
                tm_next    = LIM_W'(x_reg) + LIM_W'(q_reg);
                state_next = S_LIM;
            end
            S_LIM:
            begin
                lim4_next  = (tm_reg << 1) - LIM_W'(x_reg);
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        if (cfg_we)
            state_next = S_LOAD;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            x_reg     <= NUM_W'(2) << FRAC_BITS;
            q_reg     <= NUM_W'(1) << FRAC_BITS;
            tm_reg    <= LIM_W'(3) << FRAC_BITS;
            lim4_reg  <= LIM_W'(4) << FRAC_BITS;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            x_reg     <= x_next;
            q_reg     <= q_next;
            tm_reg    <= tm_next;
            lim4_reg  <= lim4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
    end

    assign acc      = acc_reg;
    assign vel      = vel_reg;
    assign lim.x    = x_reg;
    assign lim.q    = q_reg;
    assign lim.tm   = tm_reg;
    assign lim.lim4 = lim4_reg;
    assign busy     = state_reg != S_IDLE;

    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> busy)
        else $error("setup not busy after a register write");

endmodule
`default_nettype wire

FILE: rtl/svp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svp_front
// Takes a time point and sorts it into its profile phase, working out the
// time offset that the ramp arithmetic needs.
// ----------------------------------------------------------------------------
module svp_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              take,
    input  wire logic signed [svp_pkg::DATA_W-1:0] time_point,
    input  wire logic [svp_pkg::DATA_W-1:0]        acc,
    input  wire logic [svp_pkg::DATA_W-1:0]        vel,
    input  wire svp_pkg::svp_limits_t              lim,
    output logic                                   item_valid,
    output svp_pkg::svp_item_t                     item
);
    import svp_pkg::*;

    svp_item_t        item_reg, item_next;
    logic             valid_reg;
    logic [LIM_W-1:0] tw, t2, x_l, q_l;
    logic             nonpos;

    assign tw     = LIM_W'(time_point[DATA_W-2:0]);
    assign t2     = tw << 1;
    assign x_l    = LIM_W'(lim.x);
    assign q_l    = LIM_W'(lim.q);
    assign nonpos = time_point[DATA_W-1] || (time_point == '0);

    always_comb
    begin
        item_next.phase  = PH_IDLE;
        item_next.err    = 1'b0;
        item_next.kind   = KIND_DIRECT;
        item_next.dt     = time_point[DATA_W-1:0];
        item_next.direct = '0;
        if (acc == '0 || vel == '0)
            item_next.err = 1'b1;
        else if (nonpos)
            item_next.phase = PH_IDLE;
        else if (t2 <= x_l)
        begin
            item_next.phase = PH_RISE1;
            item_next.kind  = KIND_RAMP;
        end
        else if (tw <= x_l)
        begin
            item_next.phase = PH_RISE2;
            item_next.kind  = KIND_SUB;
            item_next.dt    = DATA_W'(x_l - tw);
        end
        else if (tw <= q_l)
        begin
            item_next.phase  = PH_CRUISE;
            item_next.direct = vel;
        end
        else if (t2 <= lim.lim4)
        begin
            item_next.phase = PH_FALL1;
            item_next.kind  = KIND_SUB;
            item_next.dt    = DATA_W'(tw - q_l);
        end
        else if (tw <= lim.tm)
        begin
            item_next.phase = PH_FALL2;
            item_next.kind  = KIND_RAMP;
            item_next.dt    = DATA_W'(lim.tm - tw);
        end
        else
            item_next.phase = PH_DONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= take;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule
`default_nettype wire

FILE: rtl/svp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svp_queue
// Two-entry queue between the classifier and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module svp_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire svp_pkg::svp_item_t push_item,
    output logic                    pop,
    output svp_pkg::svp_item_t      pop_item
);
    import svp_pkg::*;

    svp_item_t  entry_reg [0:1];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    // the back end never stalls, so the head leaves as soon as it is there
    assign pop        = count_reg != 2'd0;
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign count_next = count_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg != 2'd2)
        else $error("transfer into a full queue");

endmodule
`default_nettype wire

FILE: rtl/svp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svp_back
// Ramp arithmetic: squares the time offset, scales by the acceleration and
// divides by the ramp time in a bit-per-stage pipelined divider.
// ----------------------------------------------------------------------------
module svp_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire svp_pkg::svp_item_t         in_item,
    input  wire logic [svp_pkg::DATA_W-1:0] acc,
    input  wire logic [svp_pkg::DATA_W-1:0] vel,
    input  wire logic [svp_pkg::NUM_W-1:0]  x,
    output logic                            done,
    output logic [svp_pkg::DATA_W-1:0]      velocity_out,
    output logic [2:0]                      phase,
    output logic                            config_error
);
    import svp_pkg::*;

    localparam int NSTG = DATA_W;

    svp_meta_t          meta_in;
    svp_meta_t          meta1_reg, meta2_reg, meta3_reg;
    logic               v1_reg, v2_reg, v3_reg;
    logic [SQ_W-1:0]    sq1_reg;
    logic [SQ_W-1:0]    plo2_reg, phi2_reg;
    logic [PROD_W-1:0]  n3_reg;
    logic [DEN_W-1:0]   den;
    logic [SQ_W-1:0]    n_hi;

    svp_meta_t          meta_a [0:NSTG];
    logic [NSTG:0]      vld_a;
    logic [NSTG:0]      sat_a;
    logic [DEN_W-1:0]   rem_a  [0:NSTG];
    logic [DATA_W-1:0]  low_a  [0:NSTG];
    logic [DATA_W-1:0]  quo_a  [0:NSTG];

    logic [DATA_W-1:0]  ramp, vel_res;
    logic               done_reg;
    logic [DATA_W-1:0]  vel_out_reg;
    logic [2:0]         phase_reg;
    logic               err_reg;

    assign meta_in.phase  = in_item.phase;
    assign meta_in.err    = in_item.err;
    assign meta_in.kind   = in_item.kind;
    assign meta_in.direct = in_item.direct;

    assign den  = {x, FRAC_BITS'(0)};
    assign n_hi = n3_reg[PROD_W-1:DATA_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            vld_a[0] <= 1'b0;
        end
        else
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            vld_a[0] <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        meta1_reg <= meta_in;
        sq1_reg   <= in_item.dt * in_item.dt;
        meta2_reg <= meta1_reg;
        plo2_reg  <= acc * sq1_reg[DATA_W-1:0];
        phi2_reg  <= acc * sq1_reg[SQ_W-1:DATA_W];
        meta3_reg <= meta2_reg;
        n3_reg    <= PROD_W'(plo2_reg) + {phi2_reg, DATA_W'(0)};
        // quotient at or above 2^32 saturates, a zero divisor included
        meta_a[0] <= meta3_reg;
        sat_a[0]  <= {1'b0, n_hi} >= den;
        rem_a[0]  <= DEN_W'(n_hi);
        low_a[0]  <= n3_reg[DATA_W-1:0];
        quo_a[0]  <= '0;
    end

    for (genvar k = 0; k < NSTG; k++)
    begin : g_div
        logic [DEN_W:0] rem_sh;
        logic           ge;
        logic [DEN_W:0] rem_diff;

        assign rem_sh   = {rem_a[k], low_a[k][DATA_W-1]};
        assign ge       = rem_sh >= {1'b0, den};
        assign rem_diff = rem_sh - {1'b0, den};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_a[k+1] <= 1'b0;
            else
                vld_a[k+1] <= vld_a[k];
        end

        always_ff @(posedge clk)
        begin
            meta_a[k+1] <= meta_a[k];
            sat_a[k+1]  <= sat_a[k];
            rem_a[k+1]  <= ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            low_a[k+1]  <= low_a[k] << 1;
            quo_a[k+1]  <= {quo_a[k][DATA_W-2:0], ge};
        end
    end

    assign ramp = sat_a[NSTG] ? MAX_VAL : quo_a[NSTG];

    always_comb
    begin
        case (meta_a[NSTG].kind)
            KIND_RAMP: vel_res = ramp;
            KIND_SUB:  vel_res = (vel > ramp) ? vel - ramp : '0;
            default:   vel_res = meta_a[NSTG].direct;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld_a[NSTG];
    end

    always_ff @(posedge clk)
    begin
        vel_out_reg <= vel_res;
        phase_reg   <= meta_a[NSTG].phase;
        err_reg     <= meta_a[NSTG].err;
    end

    assign done         = done_reg;
    assign velocity_out = vel_out_reg;
    assign phase        = phase_reg;
    assign config_error = err_reg;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && config_error |-> velocity_out == '0 && phase == PH_IDLE)
        else $error("error result with non-zero velocity or phase");

    a_rest_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (phase == PH_IDLE || phase == PH_DONE) |-> velocity_out == '0)
        else $error("velocity outside the move");

    a_cruise: assert property (@(posedge clk) disable iff (!rst_n)
        done && phase == PH_CRUISE |-> velocity_out == vel)
        else $error("cruise velocity mismatch");

endmodule
`default_nettype wire

FILE: rtl/smooth_velocity_profile_unit.sv
// a taken start passes the classifier, queue, square, scale, sum, divider and output registers to done
// throughput: one time point per cycle while busy is low, set by the bit-per-stage ramp divider
// a register write makes busy high while a one-bit-a-cycle divider
// derives the ramp time and cruise end; no start is taken then
// reset: registers return to 1.0 with derived limits preloaded, pipeline empties
// the receiver cannot stall; every result is held on the ports for one cycle
`default_nettype none
// ----------------------------------------------------------------------------
// smooth_velocity_profile_unit
// Commanded velocity of an S-curve move at a given time point.
// ----------------------------------------------------------------------------
module smooth_velocity_profile_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic signed [svp_pkg::DATA_W-1:0] time_point,
    input  wire logic                              cfg_we,
    input  wire logic [svp_pkg::IDX_W-1:0]         cfg_index,
    input  wire logic [svp_pkg::DATA_W-1:0]        cfg_data,
    output logic                                   done,
    output logic [svp_pkg::DATA_W-1:0]             velocity_out,
    output logic [2:0]                             phase,
    output logic                                   config_error
);
    import svp_pkg::*;

    logic [DATA_W-1:0] acc, vel;
    svp_limits_t       lim;
    logic              setup_busy;
    logic              take;
    logic              front_valid;
    svp_item_t         front_item;
    logic              q_pop;
    svp_item_t         q_item;

    assign busy = setup_busy;
    assign take = start && !setup_busy;

    svp_setup u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .acc       (acc),
        .vel       (vel),
        .lim       (lim),
        .busy      (setup_busy)
    );

    svp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .time_point (time_point),
        .acc        (acc),
        .vel        (vel),
        .lim        (lim),
        .item_valid (front_valid),
        .item       (front_item)
    );

    svp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .push_item (front_item),
        .pop       (q_pop),
        .pop_item  (q_item)
    );

    svp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (q_pop),
        .in_item      (q_item),
        .acc          (acc),
        .vel          (vel),
        .x            (lim.x),
        .done         (done),
        .velocity_out (velocity_out),
        .phase        (phase),
        .config_error (config_error)
    );

endmodule
`default_nettype wire
